[sv/weighted_degree_rbf_kernel_top_defines.svh]
// Assertion macros shared by the weighted-degree RBF kernel RTL.
// No dependencies; include with the bare file name.
`ifndef WEIGHTED_DEGREE_RBF_KERNEL_TOP_DEFINES_SVH
`define WEIGHTED_DEGREE_RBF_KERNEL_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define WDK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define WDK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wdk_pkg.sv]
// Shared types, constants and ROM functions for the weighted-degree RBF kernel.
// No dependencies.
package wdk_pkg;

    localparam int unsigned FactorCount = 14;

    typedef logic [31:0] t_q32;

    // Group record handed from the front to the back through the queue.
    typedef struct packed {
        logic [63:0] sum;
        logic        is_group;
        logic        is_last;
        logic        partial;
    } t_grp;

    function automatic logic [31:0] exp_factor(input int unsigned k);
        logic [31:0] f;
        case (k)
            0:       f = 32'd4290775039;
            1:       f = 32'd4286586875;
            2:       f = 32'd4278222805;
            3:       f = 32'd4261543596;
            4:       f = 32'd4228380001;
            5:       f = 32'd4162825044;
            6:       f = 32'd4034748365;
            7:       f = 32'd3790295335;
            8:       f = 32'd3344923893;
            9:       f = 32'd2605029347;
            10:      f = 32'd1580030169;
            11:      f = 32'd581260616;
            12:      f = 32'd78665070;
            13:      f = 32'd1440801;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

    // Elaboration-time exp ROM entry for table index idx.
    function automatic logic [15:0] exp_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] v;
        int          t;
        v = 64'h1_0000_0000;
        for (int j = 0; j < bits; j++) begin
            t = j + 14 - bits;
            if (((idx >> j) & 1) != 0 && t >= 0 && t < FactorCount) begin
                v = (v * {32'd0, exp_factor(t)} + 64'h8000_0000) >> 32;
            end
        end
        v = (v + 64'd32768) >> 16;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

[sv/wdk_front.sv]
// Front end: squares element differences and sums them per group.
// Depends on wdk_pkg.
module wdk_front #(
    parameter int unsigned MAX_GROUP = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [31:0] i_a_value,
    input  logic signed [31:0] i_b_value,
    input  logic              i_last,
    input  logic [4:0]        i_group_size,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output wdk_pkg::t_grp     o_q_data
);
    localparam int unsigned GW = $clog2(MAX_GROUP + 1);

    // stage 1: difference magnitude and square
    logic              r_s1_valid;
    logic [32:0]       r_mag;
    logic              r_s1_last;
    logic [63:0]       r_group_sum, n_group_sum;
    logic [GW-1:0]     r_fill, n_fill;
    logic              r_out_valid;
    wdk_pkg::t_grp     r_out;

    logic signed [32:0] diff;
    logic [65:0]        sq_full;
    logic [64:0]        sum_ext;
    logic [63:0]        sum_sat;
    logic [GW-1:0]      gs_eff;
    logic               s1_adv;
    logic               out_free;

    assign diff = 33'(i_a_value) - 33'(i_b_value);
    assign gs_eff = (i_group_size == 5'd0) ? GW'(1) :
                    (32'(i_group_size) > MAX_GROUP) ? GW'(MAX_GROUP) : GW'(i_group_size);
    assign sq_full = 66'(r_mag) * 66'(r_mag);
    assign sum_ext = 65'(r_group_sum) + 65'(sq_full[65:16]);
    assign sum_sat = sum_ext[64] ? '1 : sum_ext[63:0];
    assign out_free = !r_out_valid || i_q_ready;
    assign s1_adv = r_s1_valid && out_free;
    assign o_ready = !r_s1_valid || out_free;
    assign o_q_valid = r_out_valid;
    assign o_q_data = r_out;

    always_comb begin
        n_group_sum = r_group_sum;
        n_fill = r_fill;
        if (s1_adv) begin
            if (r_fill + GW'(1) >= gs_eff || r_s1_last) begin
                n_group_sum = '0;
                n_fill = '0;
            end else begin
                n_group_sum = sum_sat;
                n_fill = r_fill + GW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_group_sum <= '0;
            r_fill <= '0;
        end else begin
            r_group_sum <= n_group_sum;
            r_fill <= n_fill;
            if (i_valid && o_ready) begin
                r_s1_valid <= 1'b1;
                r_mag <= diff[32] ? 33'(-diff) : 33'(diff);
                r_s1_last <= i_last;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= (r_fill + GW'(1) >= gs_eff) || r_s1_last;
                r_out.sum <= sum_sat;
                r_out.is_group <= (r_fill + GW'(1) >= gs_eff);
                r_out.is_last <= r_s1_last;
                r_out.partial <= (r_fill + GW'(1) < gs_eff);
            end else if (i_q_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `include "weighted_degree_rbf_kernel_top_defines.svh"
    `WDK_ASSERT_IMP(a_fill_below_group, i_clk, i_rst_n, 1'b1, r_fill < GW'(MAX_GROUP), "group fill overran")
    `WDK_ASSERT_IMP(a_out_has_reason, i_clk, i_rst_n, r_out_valid, r_out.is_group || r_out.is_last, "empty record")
    `WDK_ASSERT_NEXT(a_fill_clears_on_last, i_clk, i_rst_n, s1_adv && r_s1_last, r_fill == '0, "fill kept after last")

endmodule

[sv/wdk_fifo.sv]
// Short queue of group records between front and back.
// Depends on wdk_pkg.
module wdk_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wdk_pkg::t_grp i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wdk_pkg::t_grp o_data
);
    wdk_pkg::t_grp r_mem [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end
endmodule

[sv/wdk_back.sv]
// Back end: window sums, exp and weight lookup, kernel accumulation.
// Depends on wdk_pkg.
module wdk_back #(
    parameter int unsigned MAX_DEGREE     = 8,
    parameter int unsigned EXP_TABLE_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wdk_pkg::t_grp i_data,
    input  logic [3:0]    i_degree,
    input  logic [31:0]   i_inverse_width,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_kernel_value,
    output logic          o_length_error
);
    localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
    localparam int unsigned ED = 1 << EXP_TABLE_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_TERM   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;
    localparam logic [2:0] ST_MUL_HI = 3'd5;

    logic [2:0]    r_state;
    logic [63:0]   r_win_sum [MAX_DEGREE];
    logic [DW-1:0] r_win_dep [MAX_DEGREE];
    logic [MAX_DEGREE-1:0] r_win_vld;
    logic [IW-1:0] r_idx;
    wdk_pkg::t_grp r_grp;
    logic [31:0]   r_total;
    logic [63:0]   r_wsum;
    logic [DW-1:0] r_dep;
    logic [95:0]   r_prod;
    logic          r_ovf;
    logic [15:0]   r_exp;
    logic [32:0]   r_w;
    logic [31:0]   r_out_val;
    logic          r_out_err;
    logic          r_out_valid;

    logic [DW-1:0] deg_eff;
    logic [32:0]   recip;
    logic [32:0]   recip_tab [MAX_DEGREE];
    logic [64:0]   ws_ext;
    logic [63:0]   ws_new;
    logic [63:0]   lo_prod;
    logic [63:0]   hi_prod;
    logic [IW-1:0] free_idx;
    logic          free_found;
    logic [49:0]   term_full;
    logic [32:0]   tot_ext;
    logic [79:0]   x_full;
    logic [15:0]   exp_rom [ED];
    logic [DW+32:0] w_full;

    // weight reciprocal round(2^32 / T), T = d*(d+1)/2, fixed per degree
    for (genvar g = 1; g <= MAX_DEGREE; g++) begin : g_recip
        localparam logic [63:0] TRI_CNT = 64'(g * (g + 1) / 2);
        localparam logic [32:0] RECIP_VAL = 33'((64'h1_0000_0000 + TRI_CNT / 2) / TRI_CNT);
        assign recip_tab[g-1] = RECIP_VAL;
    end

    assign deg_eff = (i_degree == 4'd0) ? DW'(1) :
                     (32'(i_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(i_degree);

    always_comb begin
        recip = '0;
        for (int d = 1; d <= MAX_DEGREE; d++) begin
            if (deg_eff == DW'(d)) recip = recip_tab[d-1];
        end
        for (int e = 0; e < ED; e++) begin
            exp_rom[e] = wdk_pkg::exp_entry(e, EXP_TABLE_BITS);
        end
        free_idx = '0;
        free_found = 1'b0;
        for (int i = MAX_DEGREE - 1; i >= 0; i--) begin
            if (!r_win_vld[i]) begin
                free_idx = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign ws_ext = 65'(r_win_sum[r_idx]) + 65'(r_grp.sum);
    assign ws_new = ws_ext[64] ? '1 : ws_ext[63:0];
    // window sum times inverse width, low and high halves on separate cycles
    assign lo_prod = 64'(ws_new[31:0]) * 64'(i_inverse_width);
    assign hi_prod = 64'(r_wsum[63:32]) * 64'(i_inverse_width);
    assign x_full = 80'(r_prod[79:16]);
    assign w_full = (DW+33)'(deg_eff - r_dep) * (DW+33)'(recip);
    assign term_full = (50'(r_exp) * 50'(r_w) + 50'h8000_0000) >> 32;
    assign tot_ext = 33'(r_total) + 33'(term_full[31:0]);
    assign o_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_kernel_value = r_out_val;
    assign o_length_error = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_win_vld <= '0;
            r_total <= '0;
            r_out_valid <= 1'b0;
            r_idx <= '0;
            for (int i = 0; i < MAX_DEGREE; i++) begin
                r_win_dep[i] <= '0;
                r_win_sum[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_grp <= i_data;
                        r_idx <= '0;
                        if (i_data.is_group) begin
                            if (free_found) begin
                                r_win_vld[free_idx] <= 1'b1;
                                r_win_sum[free_idx] <= '0;
                                r_win_dep[free_idx] <= '0;
                            end
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_SCAN: begin
                    // advance over idle slots; retire those past the degree
                    if (r_win_vld[r_idx] && r_win_dep[r_idx] < deg_eff) begin
                        r_win_sum[r_idx] <= ws_new;
                        r_wsum <= ws_new;
                        r_dep <= r_win_dep[r_idx];
                        r_prod <= 96'(lo_prod);
                        r_state <= ST_MUL_HI;
                    end else begin
                        if (r_win_vld[r_idx]) r_win_vld[r_idx] <= 1'b0;
                        if (32'(r_idx) == MAX_DEGREE - 1) begin
                            r_state <= r_grp.is_last ? ST_OUT : ST_IDLE;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                ST_MUL_HI: begin
                    r_prod <= r_prod + {hi_prod, 32'd0};
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_ovf <= |r_prod[95:64] || |x_full[79:20];
                    r_exp <= exp_rom[x_full[19:20-EXP_TABLE_BITS]];
                    r_w <= w_full[32:0];
                    r_state <= ST_TERM;
                end
                ST_TERM: begin
                    if (!r_ovf) begin
                        r_total <= (tot_ext[32] || |term_full[49:32]) ? '1 : tot_ext[31:0];
                    end
                    r_win_dep[r_idx] <= r_dep + DW'(1);
                    if (r_dep + DW'(1) >= deg_eff) r_win_vld[r_idx] <= 1'b0;
                    if (32'(r_idx) == MAX_DEGREE - 1) begin
                        r_state <= r_grp.is_last ? ST_OUT : ST_IDLE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        r_state <= ST_SCAN;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_val <= r_total;
                        r_out_err <= r_grp.partial;
                        r_total <= '0;
                        r_win_vld <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `include "weighted_degree_rbf_kernel_top_defines.svh"
    `WDK_ASSERT_NEXT(a_out_clears, i_clk, i_rst_n, r_state == ST_OUT && !r_out_valid, r_win_vld == '0 && r_total == '0, "stream state kept")
    `WDK_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready, "ready while busy")
    `WDK_ASSERT_IMP(a_mul_valid, i_clk, i_rst_n, r_state == ST_MUL, r_dep < deg_eff, "term past degree")

endmodule

[sv/weighted_degree_rbf_kernel_top.sv]
// Path: the front registers each pair's difference magnitude, then the group record;
// the queue passes records to the back, which scans its windows for a full group.
// Throughput: one pair per cycle at the front while the queue and back keep up; the
// back takes no new group until done with the last; queue depth 4 absorbs bursts.
// Reset: synchronous, active low; clears all control state and registers to
// degree 1, group_size 1, inverse_width 1.0.
module weighted_degree_rbf_kernel_top #(
    parameter int unsigned MAX_DEGREE     = 8,
    parameter int unsigned MAX_GROUP      = 16,
    parameter int unsigned EXP_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_a_value,
    input  logic signed [31:0] i_b_value,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_kernel_value,
    output logic               o_length_error,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_GROUP  = 2'd1;
    localparam logic [1:0] REG_INVW   = 2'd2;

    logic [3:0]  r_degree;
    logic [4:0]  r_group_size;
    logic [31:0] r_inverse_width;

    // config writes: hold until rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 4'd1;
            r_group_size <= 5'd1;
            r_inverse_width <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEGREE: r_degree <= i_cfg_data[3:0];
                REG_GROUP:  r_group_size <= i_cfg_data[4:0];
                REG_INVW:   r_inverse_width <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    logic          f_valid, f_ready, b_valid, b_ready;
    wdk_pkg::t_grp f_data, b_data;

    // front: square and group-sum each beat
    wdk_front #(.MAX_GROUP(MAX_GROUP)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_a_value, .i_b_value, .i_last,
        .i_group_size(r_group_size),
        .o_q_valid(f_valid), .i_q_ready(f_ready), .o_q_data(f_data)
    );

    wdk_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_data),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(b_data)
    );

    // back: window sweep and kernel sum
    wdk_back #(.MAX_DEGREE(MAX_DEGREE), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(b_valid), .o_ready(b_ready), .i_data(b_data),
        .i_degree(r_degree), .i_inverse_width(r_inverse_width),
        .o_valid, .i_ready, .o_kernel_value, .o_length_error
    );
endmodule
